### design/gnc_pkg.sv
// Shared types and constants for the neighbour-count grid block.
`default_nettype none

package gnc_pkg;

    // Default build parameters
    localparam int GRID_DIM_DEF   = 64;
    localparam int CELL_BITS_DEF  = 8;
    localparam int MAX_RADIUS_DEF = 7;

    // Fixed field widths
    localparam int OP_W      = 3;
    localparam int COORD_W   = 8;
    localparam int VALUE_W   = 8;
    localparam int RADIUS_W  = 8;
    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_IDX  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_IDX = 1'b1;

    // Reset value of both grid dimension registers
    localparam logic [CFG_W-1:0] CFG_DIM_RESET = 7'd64;

    typedef enum logic [OP_W-1:0] {
        OP_READ   = 3'd0,
        OP_COUNT  = 3'd1,
        OP_WRITE  = 3'd2,
        OP_COMMIT = 3'd3,
        OP_LOAD   = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_WAIT,
        ST_COUNT,
        ST_COPY,
        ST_DRAIN,
        ST_DONE
    } state_t;

    // Sequencer status toward the top level
    typedef struct packed {
        logic idle;
        logic res_valid;
    } gnc_status_t;

    // One finished result
    typedef struct packed {
        logic [VALUE_W-1:0] read_value;
        logic [VALUE_W-1:0] match_count;
    } gnc_result_t;

endpackage

`default_nettype wire

### design/gnc_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none

module gnc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### design/gnc_seq.sv
// Sequencer: clears, reads, counts windows, writes and copies the two grid memories.
`default_nettype none

module gnc_seq
    import gnc_pkg::*;
#(
    parameter int GRID_DIM   = GRID_DIM_DEF,
    parameter int CELL_BITS  = CELL_BITS_DEF,
    parameter int MAX_RADIUS = MAX_RADIUS_DEF,
    localparam int DEPTH     = GRID_DIM * GRID_DIM,
    localparam int AW        = $clog2(DEPTH)
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                accept,
    input  wire logic [OP_W-1:0]     operation,
    input  wire logic [COORD_W-1:0]  col,
    input  wire logic [COORD_W-1:0]  row,
    input  wire logic [VALUE_W-1:0]  cell_value,
    input  wire logic [RADIUS_W-1:0] radius,
    input  wire logic [CFG_W-1:0]    grid_width,
    input  wire logic [CFG_W-1:0]    grid_height,
    input  wire logic                res_ready,
    output gnc_status_t              status,
    output gnc_result_t              result,
    output logic                     cur_we,
    output logic [AW-1:0]            cur_waddr,
    output logic [CELL_BITS-1:0]     cur_wdata,
    output logic [AW-1:0]            cur_raddr,
    input  wire logic [CELL_BITS-1:0] cur_rdata,
    output logic                     nxt_we,
    output logic [AW-1:0]            nxt_waddr,
    output logic [CELL_BITS-1:0]     nxt_wdata,
    output logic [AW-1:0]            nxt_raddr,
    input  wire logic [CELL_BITS-1:0] nxt_rdata
);

    localparam int DW  = $clog2(GRID_DIM);
    localparam int RW  = $clog2(MAX_RADIUS + 1);
    localparam int OW  = RW + 1;
    localparam int CW  = ((OW > COORD_W) ? OW : COORD_W) + 1;
    localparam int NW  = $clog2((2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1));
    localparam int CMW = (CELL_BITS > VALUE_W) ? CELL_BITS : VALUE_W;
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

    state_t                  state_reg, state_next;
    op_t                     op_reg, op_next;
    logic signed [COORD_W-1:0] col_reg, col_next;
    logic signed [COORD_W-1:0] row_reg, row_next;
    logic [VALUE_W-1:0]      val_reg, val_next;
    logic [RW-1:0]           rad_reg, rad_next;
    logic signed [OW-1:0]    dx_reg, dx_next;
    logic signed [OW-1:0]    dy_reg, dy_next;
    logic [AW-1:0]           idx_reg, idx_next;
    logic                    pipe_cnt_reg, pipe_cnt_next;
    logic                    pipe_in_reg, pipe_in_next;
    logic                    pipe_copy_reg, pipe_copy_next;
    logic [AW-1:0]           pipe_addr_reg, pipe_addr_next;
    logic [VALUE_W-1:0]      rd_reg, rd_next;
    logic [NW-1:0]           cnt_reg, cnt_next;

    logic [RW-1:0]           rad_in;
    logic signed [OW-1:0]    d_in, d_cur;
    logic [CFG_W-1:0]        used_w, used_h;
    logic signed [CW-1:0]    cc, rr;
    logic                    in_bounds, center, last_pos, match;
    logic [AW-1:0]           addr;
    logic [CMW-1:0]          cell_x, val_x;

    // Radius saturation and signed half-size
    assign rad_in = (radius > RADIUS_W'(MAX_RADIUS)) ? RW'(MAX_RADIUS) : RW'(radius);
    assign d_in   = $signed({1'b0, rad_in});
    assign d_cur  = $signed({1'b0, rad_reg});

    // Grid dimensions in use
    assign used_w = (grid_width > CFG_W'(GRID_DIM)) ? CFG_W'(GRID_DIM) : grid_width;
    assign used_h = (grid_height > CFG_W'(GRID_DIM)) ? CFG_W'(GRID_DIM) : grid_height;

    // Window position and bounds check
    assign cc     = CW'(col_reg) + CW'(dx_reg);
    assign rr     = CW'(row_reg) + CW'(dy_reg);
    assign in_bounds = !cc[CW-1] && !rr[CW-1]
                       && (CW'($unsigned(cc)) < CW'(used_w))
                       && (CW'($unsigned(rr)) < CW'(used_h));
    assign center   = (dx_reg == '0) && (dy_reg == '0);
    assign last_pos = (dx_reg == d_cur) && (dy_reg == d_cur);
    assign addr     = AW'(rr[DW-1:0]) * AW'(GRID_DIM) + AW'(cc[DW-1:0]);

    // Compare of the cell from the registered read port; outside cells read as zero
    assign cell_x = pipe_in_reg ? CMW'(cur_rdata) : '0;
    assign val_x  = CMW'(val_reg);
    assign match  = (cell_x == val_x);

    assign cur_raddr = addr;
    assign nxt_raddr = idx_reg;

    assign result.read_value  = rd_reg;
    assign result.match_count = VALUE_W'(cnt_reg);

    // Next state, memory control and result update
    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        val_next       = val_reg;
        rad_next       = rad_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        idx_next       = idx_reg;
        pipe_cnt_next  = 1'b0;
        pipe_in_next   = pipe_in_reg;
        pipe_copy_next = 1'b0;
        pipe_addr_next = pipe_addr_reg;
        rd_next        = rd_reg;
        cnt_next       = cnt_reg;
        status         = '0;
        cur_we         = 1'b0;
        cur_waddr      = addr;
        cur_wdata      = CELL_BITS'(val_reg);
        nxt_we         = 1'b0;
        nxt_waddr      = addr;
        nxt_wdata      = CELL_BITS'(val_reg);

        // count tail of the window pipeline
        if (pipe_cnt_reg && match)
        begin
            cnt_next = cnt_reg + NW'(1);
        end

        // copy tail: data from the registered read port of the next grid
        if (pipe_copy_reg)
        begin
            cur_we    = 1'b1;
            cur_waddr = pipe_addr_reg;
            cur_wdata = nxt_rdata;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                cur_we    = 1'b1;
                cur_waddr = idx_reg;
                cur_wdata = '0;
                nxt_we    = 1'b1;
                nxt_waddr = idx_reg;
                nxt_wdata = '0;
                idx_next  = idx_reg + AW'(1);
                if (idx_reg == LAST_IDX)
                begin
                    idx_next   = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                status.idle = 1'b1;
                if (accept)
                begin
                    op_next    = op_t'(operation);
                    col_next   = $signed(col);
                    row_next   = $signed(row);
                    val_next   = cell_value;
                    rad_next   = rad_in;
                    dx_next    = (op_t'(operation) == OP_COUNT) ? -d_in : '0;
                    dy_next    = (op_t'(operation) == OP_COUNT) ? -d_in : '0;
                    rd_next    = '0;
                    cnt_next   = '0;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                unique case (op_reg)
                    OP_READ:
                    begin
                        pipe_in_next = in_bounds;
                        state_next   = ST_WAIT;
                    end
                    OP_COUNT:
                    begin
                        state_next = (rad_reg == '0) ? ST_DONE : ST_COUNT;
                    end
                    OP_WRITE:
                    begin
                        nxt_we     = in_bounds;
                        state_next = ST_DONE;
                    end
                    OP_LOAD:
                    begin
                        cur_we     = in_bounds;
                        state_next = ST_DONE;
                    end
                    OP_COMMIT:
                    begin
                        idx_next   = '0;
                        state_next = ST_COPY;
                    end
                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_WAIT:
            begin
                rd_next    = pipe_in_reg ? VALUE_W'(cur_rdata) : '0;
                state_next = ST_DONE;
            end
            ST_COUNT:
            begin
                // one window cell per cycle, row by row
                pipe_cnt_next = !center;
                pipe_in_next  = in_bounds;
                if (dx_reg == d_cur)
                begin
                    dx_next = -d_cur;
                    dy_next = dy_reg + OW'(1);
                end
                else
                begin
                    dx_next = dx_reg + OW'(1);
                end
                if (last_pos)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_COPY:
            begin
                pipe_copy_next = 1'b1;
                pipe_addr_next = idx_reg;
                idx_next       = idx_reg + AW'(1);
                if (idx_reg == LAST_IDX)
                begin
                    idx_next   = '0;
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                status.res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            idx_reg       <= '0;
            pipe_cnt_reg  <= 1'b0;
            pipe_copy_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            pipe_cnt_reg  <= pipe_cnt_next;
            pipe_copy_reg <= pipe_copy_next;
        end
    end

    // Item and datapath registers
    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        col_reg       <= col_next;
        row_reg       <= row_next;
        val_reg       <= val_next;
        rad_reg       <= rad_next;
        dx_reg        <= dx_next;
        dy_reg        <= dy_next;
        pipe_in_reg   <= pipe_in_next;
        pipe_addr_reg <= pipe_addr_next;
        rd_reg        <= rd_next;
        cnt_reg       <= cnt_next;
    end

endmodule

`default_nettype wire

### design/grid_neighbour_count_table.sv
// Top level of the double-buffered neighbour-count grid.
//
//  Channel | Signals                                           | Direction
//  --------+---------------------------------------------------+----------
//  in      | in_valid, in_stall, operation, col, row,          | request in
//          | cell_value, radius                                |
//  out     | out_valid, out_stall, read_value, match_count     | request out
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data         | write in
//
// One request at a time. After accept the sequencer runs EXEC, then WAIT for
// a read, one COUNT state per window cell and DRAIN for a count (none for
// radius 0), one COPY state per cell and DRAIN for a commit, then DONE; the
// next request can be taken in the cycle after DONE loads the output register.
// The window walk issues one read of the current-grid memory per cycle;
// commit copies one cell per cycle. After reset both memories are cleared, one
// entry per cycle, while in_stall is held high; cfg writes are taken throughout.
// A new request is accepted while the previous result waits behind out_stall.
`default_nettype none

module grid_neighbour_count_table
    import gnc_pkg::*;
#(
    parameter int GRID_DIM   = GRID_DIM_DEF,
    parameter int CELL_BITS  = CELL_BITS_DEF,
    parameter int MAX_RADIUS = MAX_RADIUS_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic [OP_W-1:0]      operation,
    input  wire logic [COORD_W-1:0]   col,
    input  wire logic [COORD_W-1:0]   row,
    input  wire logic [VALUE_W-1:0]   cell_value,
    input  wire logic [RADIUS_W-1:0]  radius,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic [VALUE_W-1:0]        read_value,
    output logic [VALUE_W-1:0]        match_count,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data
);

    localparam int DEPTH = GRID_DIM * GRID_DIM;
    localparam int AW    = $clog2(DEPTH);

    logic [CFG_W-1:0]    grid_width_reg, grid_width_next;
    logic [CFG_W-1:0]    grid_height_reg, grid_height_next;
    logic                out_valid_reg, out_valid_next;
    logic [VALUE_W-1:0]  read_value_reg, match_count_reg;

    gnc_status_t         status;
    gnc_result_t         result;
    logic                accept, res_ready, res_load;
    logic                cur_we, nxt_we;
    logic [AW-1:0]       cur_waddr, cur_raddr, nxt_waddr, nxt_raddr;
    logic [CELL_BITS-1:0] cur_wdata, cur_rdata, nxt_wdata, nxt_rdata;

    // Input handshake
    assign in_stall  = !status.idle;
    assign accept    = in_valid && !in_stall;

    // Output register handshake
    assign res_ready = !out_valid_reg || !out_stall;
    assign res_load  = status.res_valid && res_ready;

    // Configuration port always ready
    assign cfg_ready = 1'b1;

    // Configuration register decode
    always_comb
    begin
        grid_width_next  = grid_width_reg;
        grid_height_next = grid_height_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_WIDTH_IDX:  grid_width_next  = cfg_data;
                CFG_HEIGHT_IDX: grid_height_next = cfg_data;
                default:        grid_width_next  = grid_width_reg;
            endcase
        end
    end

    // Output valid update
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= CFG_DIM_RESET;
            grid_height_reg <= CFG_DIM_RESET;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            grid_width_reg  <= grid_width_next;
            grid_height_reg <= grid_height_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            read_value_reg  <= result.read_value;
            match_count_reg <= result.match_count;
        end
    end

    assign out_valid   = out_valid_reg;
    assign read_value  = read_value_reg;
    assign match_count = match_count_reg;

    // Sequencer
    gnc_seq #(
        .GRID_DIM   (GRID_DIM),
        .CELL_BITS  (CELL_BITS),
        .MAX_RADIUS (MAX_RADIUS)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .operation   (operation),
        .col         (col),
        .row         (row),
        .cell_value  (cell_value),
        .radius      (radius),
        .grid_width  (grid_width_reg),
        .grid_height (grid_height_reg),
        .res_ready   (res_ready),
        .status      (status),
        .result      (result),
        .cur_we      (cur_we),
        .cur_waddr   (cur_waddr),
        .cur_wdata   (cur_wdata),
        .cur_raddr   (cur_raddr),
        .cur_rdata   (cur_rdata),
        .nxt_we      (nxt_we),
        .nxt_waddr   (nxt_waddr),
        .nxt_wdata   (nxt_wdata),
        .nxt_raddr   (nxt_raddr),
        .nxt_rdata   (nxt_rdata)
    );

    // Current grid
    gnc_ram #(
        .WIDTH (CELL_BITS),
        .DEPTH (DEPTH)
    ) u_cur_ram (
        .clk   (clk),
        .we    (cur_we),
        .waddr (cur_waddr),
        .wdata (cur_wdata),
        .raddr (cur_raddr),
        .rdata (cur_rdata)
    );

    // Next grid
    gnc_ram #(
        .WIDTH (CELL_BITS),
        .DEPTH (DEPTH)
    ) u_nxt_ram (
        .clk   (clk),
        .we    (nxt_we),
        .waddr (nxt_waddr),
        .wdata (nxt_wdata),
        .raddr (nxt_raddr),
        .rdata (nxt_rdata)
    );

    // A request keeps the sequencer busy on the following cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> in_stall)
        else $error("request accepted but sequencer not busy");

    // No grid memory write while waiting for a request
    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        status.idle |-> !(cur_we || nxt_we))
        else $error("grid memory written while idle");

    // The output register fills only from a finished result
    a_out_from_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(status.res_valid))
        else $error("output valid without a finished result");

endmodule

`default_nettype wire
